/* rtl/ihex_pkg.sv */
package ihex_pkg;

  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_HEAD_H = 3'd1,
    PH_HEAD_L = 3'd2,
    PH_DATA_H = 3'd3,
    PH_DATA_L = 3'd4,
    PH_SUM_H  = 3'd5,
    PH_SUM_L  = 3'd6,
    PH_STOP   = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_END    = 3'd1,
    ST_NOTHEX = 3'd2,
    ST_TYPE   = 3'd3,
    ST_CSUM   = 3'd4
  } status_t;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] DIGIT_TEN = 8'd10;

  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;

  localparam int OUT_TDATA_W = 32;

  // Bit 4 set marks a character that is not a hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    logic [7:0] v;
    begin
      v = 8'd0;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        v = ch - CH_ZERO;
        hex_digit = {1'b0, v[3:0]};
      end else if (ch >= CH_UA && ch <= CH_UF) begin
        v = ch - CH_UA + DIGIT_TEN;
        hex_digit = {1'b0, v[3:0]};
      end else if (ch >= CH_LA && ch <= CH_LF) begin
        v = ch - CH_LA + DIGIT_TEN;
        hex_digit = {1'b0, v[3:0]};
      end else begin
        hex_digit = 5'b10000;
      end
    end
  endfunction

endpackage

/* rtl/intel_hex_record_loader.sv */
// Intel HEX record loader.
// Input stream: one ASCII character per request on in_tdata. Characters before
// a ':' are skipped; the header, data bytes and checksum follow as hex pairs.
// Output stream: exactly one result per accepted character, carrying a write
// strobe, the 16-bit target address, the data byte and the load status.
// A data byte yields write_valid = 1 on the result of its low digit.
// Throughput: one character per cycle while in_tready is high; the parser state
// is registered from the accepted character and the current state.
// The result side holds an output register and a one-entry skid register, so
// a character is still taken while one result waits; in_tready drops only
// when both are full, and rises again once out_tready drains the skid entry.
// Once an end record, a bad digit, an unknown type or a checksum failure has
// latched a status, characters are still consumed and each result repeats
// that status with no write.
// Reset (rst_n low, synchronous) returns the parser to waiting for ':' with
// status OK and empties both output registers.
module intel_hex_record_loader
  import ihex_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] char_in
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] write_valid, [16:1] write_address, [24:17] write_byte,
  // [27:25] load_status, [31:28] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  nibble_r, nibble_nxt;
  logic [1:0]  hidx_r, hidx_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  rtype_r, rtype_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  sum_r, sum_nxt;
  status_t     status_r, status_nxt;

  logic [OUT_TDATA_W-1:0] res;
  logic        wv;
  logic [15:0] wa;
  logic [7:0]  wb;
  logic [4:0]  dig;
  logic [7:0]  byte_v;
  logic [7:0]  left_dec;

  logic                   out_valid_r, skid_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, skid_data_r;
  logic                   acc, take;

  assign in_tready  = ~skid_valid_r;
  assign acc        = in_tvalid & in_tready;
  assign take       = out_valid_r & out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign dig      = hex_digit(in_tdata);
  assign byte_v   = nibble_r | {4'd0, dig[3:0]};
  assign left_dec = left_r - 8'd1;

  // Next parser state for the current character
  always_comb begin
    phase_nxt  = phase_r;
    nibble_nxt = nibble_r;
    hidx_nxt   = hidx_r;
    len_nxt    = len_r;
    addr_nxt   = addr_r;
    rtype_nxt  = rtype_r;
    left_nxt   = left_r;
    sum_nxt    = sum_r;
    status_nxt = status_r;
    wv = 1'b0;
    wa = 16'd0;
    wb = 8'd0;
    unique case (phase_r)
      PH_WAIT: begin
        if (in_tdata == CH_COLON) begin
          sum_nxt   = 8'd0;
          hidx_nxt  = 2'd0;
          phase_nxt = PH_HEAD_H;
        end
      end
      PH_HEAD_H, PH_DATA_H, PH_SUM_H: begin
        if (dig[4]) begin
          status_nxt = ST_NOTHEX;
          phase_nxt  = PH_STOP;
        end else begin
          nibble_nxt = {dig[3:0], 4'd0};
          phase_nxt  = phase_t'(phase_r + 3'd1);
        end
      end
      PH_HEAD_L, PH_DATA_L, PH_SUM_L: begin
        if (dig[4]) begin
          status_nxt = ST_NOTHEX;
          phase_nxt  = PH_STOP;
        end else begin
          nibble_nxt = byte_v;
          sum_nxt    = sum_r + byte_v;
          if (phase_r == PH_HEAD_L) begin
            unique case (hidx_r)
              2'd0: len_nxt = byte_v;
              2'd1: addr_nxt = {byte_v, addr_r[7:0]};
              2'd2: addr_nxt = {addr_r[15:8], byte_v};
              2'd3: rtype_nxt = byte_v;
              default: rtype_nxt = byte_v;
            endcase
            if (hidx_r != 2'd3) begin
              hidx_nxt  = hidx_r + 2'd1;
              phase_nxt = PH_HEAD_H;
            end else begin
              hidx_nxt = 2'd0;
              priority if (byte_v == REC_EOF) begin
                status_nxt = ST_END;
                phase_nxt  = PH_STOP;
              end else if (byte_v != REC_DATA) begin
                status_nxt = ST_TYPE;
                phase_nxt  = PH_STOP;
              end else if (len_r == 8'd0) begin
                phase_nxt = PH_SUM_H;
              end else begin
                left_nxt  = len_r;
                phase_nxt = PH_DATA_H;
              end
            end
          end else if (phase_r == PH_DATA_L) begin
            wv        = 1'b1;
            wa        = addr_r;
            wb        = byte_v;
            addr_nxt  = addr_r + 16'd1;
            left_nxt  = left_dec;
            phase_nxt = (left_dec == 8'd0) ? PH_SUM_H : PH_DATA_H;
          end else begin
            if (sum_r + byte_v == 8'd0) begin
              phase_nxt = PH_WAIT;
            end else begin
              status_nxt = ST_CSUM;
              phase_nxt  = PH_STOP;
            end
          end
        end
      end
      PH_STOP: begin
      end
      default: begin
      end
    endcase
  end

  // Result word for the current character
  always_comb begin
    res = {4'd0, status_nxt, wb, wa, wv};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT;
      nibble_r <= 8'd0;
      hidx_r   <= 2'd0;
      len_r    <= 8'd0;
      addr_r   <= 16'd0;
      rtype_r  <= 8'd0;
      left_r   <= 8'd0;
      sum_r    <= 8'd0;
      status_r <= ST_OK;
    end else if (acc) begin
      phase_r  <= phase_nxt;
      nibble_r <= nibble_nxt;
      hidx_r   <= hidx_nxt;
      len_r    <= len_nxt;
      addr_r   <= addr_nxt;
      rtype_r  <= rtype_nxt;
      left_r   <= left_nxt;
      sum_r    <= sum_nxt;
      status_r <= status_nxt;
    end
  end

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || take) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= acc;
        end else begin
          out_valid_r <= acc;
        end
      end else if (acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
        if (acc) begin
          skid_data_r <= res;
        end
      end else if (acc) begin
        out_data_r <= res;
      end
    end else if (acc) begin
      skid_data_r <= res;
    end
  end

endmodule
